/* hdl/nearest_neighbor_classifier_core_macros.svh */
// Assertion macros shared by the nearest neighbor classifier RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef NEAREST_NEIGHBOR_CLASSIFIER_CORE_MACROS_SVH
`define NEAREST_NEIGHBOR_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, checked on rising clk outside reset.
`define NNC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on rising clk outside reset.
`define NNC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/nnc_pkg.sv */
// Shared types and constants of the nearest neighbor classifier.
// No dependencies; imported by every module of the block except nnc_ram.
package nnc_pkg;

    localparam int AXIS_W  = 16;
    localparam int LABEL_W = 3;
    localparam int ENTRY_W = 3 * AXIS_W + LABEL_W;
    localparam int SQ_W    = 2 * AXIS_W;
    localparam int DIST_W  = 34;
    localparam int INDEX_W = 8;
    localparam int KIND_W  = 2;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    // Item kinds as they arrive in tuser; the fourth code is unused
    typedef enum logic [KIND_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // One decoded command handed from the front to the back
    typedef struct packed {
        op_t                      op;
        logic [LABEL_W-1:0]       label;
        logic signed [AXIS_W-1:0] gyro;
        logic signed [AXIS_W-1:0] vert;
        logic signed [AXIS_W-1:0] fwd;
    } cmd_t;

    // Queue handshake from front to back
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_port_t;

endpackage

/* hdl/nearest_neighbor_classifier_core.sv */
// Nearest neighbor classifier over a table of labelled three-axis samples.
// Input side: s_tvalid/s_tready, s_tdata holds the sample and label, s_tuser the kind.
// Output side: m_tvalid/m_tready, one transfer per query item.
// Kind 0 appends a sample (dropped when the table is full), kind 2 empties
// the table, kind 1 returns the stored sample at least squared distance,
// lowest position on a tie; kind 3 is taken and ignored.
// A two-entry command queue sits between the input decoder and the executor,
// so up to two input transfers are taken while a query scans or a result waits.
// Steps: a load or clear is executed straight from the queue in ST_IDLE; a query
// passes through the queue, one RAM read per stored entry, then difference,
// square, sum and compare stages, and the output register; an empty-table query
// goes from the queue through ST_DONE to the output register.
// The executor pops no new command while a query scans or its result waits.
// Reset empties the table at once (entry count to zero), no sweep.
// A stalled output holds its result; the executor then waits with the next
// query result, the queue fills with two more commands and s_tready drops.
// Depends on nnc_pkg, nnc_front, nnc_back, nnc_ram and the macros header.
`include "nearest_neighbor_classifier_core_macros.svh"

module nearest_neighbor_classifier_core
    import nnc_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] accel_fwd, [31:16] accel_vert, [47:32] gyro_rate,
    // [50:48] class_label, [55:51] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] match_label, [10:3] match_index, [44:11] match_distance, [47:45] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // [0] table_empty
    output logic                  m_tuser
);

    cmd_port_t q_port;
    logic      q_pop;

    nnc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_out    (q_port),
        .q_pop    (q_pop)
    );

    nnc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_in     (q_port),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Executor only pops a command the queue really holds
    `NNC_ASSERT_IMPL(a_pop_has_cmd, clk, rst_n, q_pop, q_port.valid)
    // An empty-table result carries zero label, index and distance
    `NNC_ASSERT_IMPL(a_empty_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0)
    // A popped query stops the executor from popping in the next cycle
    `NNC_ASSERT_NEXT(a_query_blocks, clk, rst_n,
        q_pop && (q_port.cmd.op == OP_QUERY), !q_pop)

endmodule

/* hdl/nnc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/nnc_front.sv */
// Front end: accepts input transfers, decodes the kind, queues commands.
// Depends on nnc_pkg.
module nnc_front
    import nnc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    output cmd_port_t             q_out,
    input  logic                  q_pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       accept;
    logic       push;
    cmd_t       cmd_in;

    assign s_tready = (fill_reg != 2'd2);
    assign accept   = s_tvalid && s_tready;

    // Decode: the unused kind is accepted and dropped
    always_comb
    begin
        cmd_in.op    = op_t'(s_tuser);
        cmd_in.fwd   = s_tdata[AXIS_W-1:0];
        cmd_in.vert  = s_tdata[2*AXIS_W-1:AXIS_W];
        cmd_in.gyro  = s_tdata[3*AXIS_W-1:2*AXIS_W];
        cmd_in.label = s_tdata[ENTRY_W-1:3*AXIS_W];
        unique case (op_t'(s_tuser))
            OP_LOAD, OP_QUERY, OP_CLEAR: push = accept;
            default:                     push = 1'b0;
        endcase
    end

    // Two-entry queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign q_out.valid = (fill_reg != 2'd0);
    assign q_out.cmd   = slot_reg[rd_ptr_reg];

endmodule

/* hdl/nnc_back.sv */
// Back end: executes load, clear and query commands against the sample RAM.
// Depends on nnc_pkg and nnc_ram.
module nnc_back
    import nnc_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_port_t             q_in,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic signed [AXIS_W-1:0] qf_reg, qv_reg, qg_reg;
    logic [DIST_W-1:0]        best_dist_reg;
    logic [ADDR_W-1:0]        best_idx_reg;
    logic [LABEL_W-1:0]       best_label_reg;
    logic                     empty_reg;
    logic [LABEL_W-1:0]       out_label_reg;
    logic [INDEX_W-1:0]       out_index_reg;
    logic [DIST_W-1:0]        out_dist_reg;
    logic                     out_empty_reg;
    logic                     m_tvalid_reg;
    logic [INDEX_W-1:0]       best_idx8;

    logic                     ram_we;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic                     issue, issue_last;

    // Scan pipeline: read, abs difference, square, sum, compare
    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic                     f1_reg, f2_reg, f3_reg, f4_reg;
    logic                     l1_reg, l2_reg, l3_reg, l4_reg;
    logic [ADDR_W-1:0]        i1_reg, i2_reg, i3_reg, i4_reg;
    logic [LABEL_W-1:0]       lb2_reg, lb3_reg, lb4_reg;
    logic [AXIS_W-1:0]        af_reg, av_reg, ag_reg;
    logic [SQ_W-1:0]          sf_reg, sv_reg, sg_reg;
    logic [DIST_W-1:0]        sum_reg;
    logic signed [AXIS_W:0]   df, dv, dg;
    logic signed [AXIS_W:0]   nf, nv, ng;
    logic                     take;

    assign q_pop      = (state_reg == ST_IDLE) && q_in.valid;
    assign ram_we     = q_pop && (q_in.cmd.op == OP_LOAD) && (count_reg < DEPTH_C);
    assign issue      = (state_reg == ST_SCAN);
    assign issue_last = (CNT_W'(addr_reg) == count_reg - CNT_W'(1));

    nnc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({q_in.cmd.label, q_in.cmd.gyro, q_in.cmd.vert, q_in.cmd.fwd}),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Signed differences and magnitudes against the query sample
    always_comb
    begin
        df = {qf_reg[AXIS_W-1], qf_reg} - {ram_rdata[AXIS_W-1], ram_rdata[AXIS_W-1:0]};
        dv = {qv_reg[AXIS_W-1], qv_reg}
           - {ram_rdata[2*AXIS_W-1], ram_rdata[2*AXIS_W-1:AXIS_W]};
        dg = {qg_reg[AXIS_W-1], qg_reg}
           - {ram_rdata[3*AXIS_W-1], ram_rdata[3*AXIS_W-1:2*AXIS_W]};
        nf = df[AXIS_W] ? -df : df;
        nv = dv[AXIS_W] ? -dv : dv;
        ng = dg[AXIS_W] ? -dg : dg;
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        f1_reg  <= (addr_reg == '0);
        l1_reg  <= issue_last;
        i1_reg  <= addr_reg;
        f2_reg  <= f1_reg;
        l2_reg  <= l1_reg;
        i2_reg  <= i1_reg;
        lb2_reg <= ram_rdata[ENTRY_W-1:3*AXIS_W];
        af_reg  <= nf[AXIS_W-1:0];
        av_reg  <= nv[AXIS_W-1:0];
        ag_reg  <= ng[AXIS_W-1:0];
        f3_reg  <= f2_reg;
        l3_reg  <= l2_reg;
        i3_reg  <= i2_reg;
        lb3_reg <= lb2_reg;
        sf_reg  <= af_reg * af_reg;
        sv_reg  <= av_reg * av_reg;
        sg_reg  <= ag_reg * ag_reg;
        f4_reg  <= f3_reg;
        l4_reg  <= l3_reg;
        i4_reg  <= i3_reg;
        lb4_reg <= lb3_reg;
        sum_reg <= DIST_W'(sf_reg) + DIST_W'(sv_reg) + DIST_W'(sg_reg);
    end

    // First entry always wins; later ones only when strictly closer
    assign take = v4_reg && (f4_reg || (sum_reg < best_dist_reg));

    // Position reported as its low eight bits
    if (ADDR_W >= INDEX_W)
    begin : g_idx_wide
        assign best_idx8 = best_idx_reg[INDEX_W-1:0];
    end
    else
    begin : g_idx_narrow
        assign best_idx8 = {{(INDEX_W - ADDR_W){1'b0}}, best_idx_reg};
    end

    // Command sequencer, scan control and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            addr_reg       <= '0;
            qf_reg         <= '0;
            qv_reg         <= '0;
            qg_reg         <= '0;
            best_dist_reg  <= '0;
            best_idx_reg   <= '0;
            best_label_reg <= '0;
            empty_reg      <= 1'b0;
            out_label_reg  <= '0;
            out_index_reg  <= '0;
            out_dist_reg   <= '0;
            out_empty_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            // A finished query reloads the output register in ST_DONE instead
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (take)
            begin
                best_dist_reg  <= sum_reg;
                best_idx_reg   <= i4_reg;
                best_label_reg <= lb4_reg;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_in.valid)
                    begin
                        unique case (q_in.cmd.op)
                            OP_LOAD:
                            begin
                                if (count_reg < DEPTH_C)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            OP_QUERY:
                            begin
                                qf_reg   <= q_in.cmd.fwd;
                                qv_reg   <= q_in.cmd.vert;
                                qg_reg   <= q_in.cmd.gyro;
                                addr_reg <= '0;
                                if (count_reg == '0)
                                begin
                                    best_dist_reg  <= '0;
                                    best_idx_reg   <= '0;
                                    best_label_reg <= '0;
                                    empty_reg      <= 1'b1;
                                    state_reg      <= ST_DONE;
                                end
                                else
                                begin
                                    empty_reg <= 1'b0;
                                    state_reg <= ST_SCAN;
                                end
                            end
                            default:
                            begin
                                count_reg <= count_reg;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (issue_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (v4_reg && l4_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        out_label_reg <= best_label_reg;
                        out_index_reg <= best_idx8;
                        out_dist_reg  <= best_dist_reg;
                        out_empty_reg <= empty_reg;
                        m_tvalid_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - LABEL_W - INDEX_W - DIST_W){1'b0}},
                       out_dist_reg, out_index_reg, out_label_reg};
    assign m_tuser  = out_empty_reg;

endmodule

/* verif/nnc_match_checker.sv */
// Checker for the nearest neighbor classifier: watches both stream channels,
// keeps its own copy of the sample table and compares every result transfer.
// Depends on nnc_pkg for field widths and item kinds.
`timescale 1ns / 100ps

module nnc_match_checker
    import nnc_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    output int                    mismatch_count,
    output int                    matches_pending
);

    // One query result as the block should report it
    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [INDEX_W-1:0] index;
        logic [DIST_W-1:0]  distance;
        logic               empty;
    } match_t;

    // Shadow table of stored samples
    logic signed [AXIS_W-1:0] tab_fwd   [TABLE_DEPTH];
    logic signed [AXIS_W-1:0] tab_vert  [TABLE_DEPTH];
    logic signed [AXIS_W-1:0] tab_gyro  [TABLE_DEPTH];
    logic [LABEL_W-1:0]       tab_label [TABLE_DEPTH];
    int                       stored_count;

    match_t pending_matches[$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Scan the stored samples; strict less-than keeps the lowest position on a tie
    function automatic match_t nearest_stored(input logic signed [AXIS_W-1:0] qf,
                                              input logic signed [AXIS_W-1:0] qv,
                                              input logic signed [AXIS_W-1:0] qg);
        match_t r;
        longint df;
        longint dv;
        longint dg;
        longint d;
        longint best_d;
        int     best;
        r = '0;
        if (stored_count == 0)
        begin
            r.empty = 1'b1;
            return r;
        end
        best   = 0;
        best_d = 0;
        for (int j = 0; j < stored_count; j++)
        begin
            df = longint'(qf) - longint'(tab_fwd[j]);
            dv = longint'(qv) - longint'(tab_vert[j]);
            dg = longint'(qg) - longint'(tab_gyro[j]);
            d  = df * df + dv * dv + dg * dg;
            if (j == 0 || d < best_d)
            begin
                best   = j;
                best_d = d;
            end
        end
        r.label    = tab_label[best];
        r.index    = best[INDEX_W-1:0];
        r.distance = best_d[DIST_W-1:0];
        return r;
    endfunction

    // Apply one accepted input transfer to the shadow state
    task automatic take_item(input logic [KIND_W-1:0] kind, input logic [IN_DATA_W-1:0] data);
        if (kind == OP_LOAD)
        begin
            // loads past a full table are dropped
            if (stored_count < TABLE_DEPTH)
            begin
                tab_fwd[stored_count]   = data[15:0];
                tab_vert[stored_count]  = data[31:16];
                tab_gyro[stored_count]  = data[47:32];
                tab_label[stored_count] = data[50:48];
                stored_count++;
            end
        end
        else if (kind == OP_CLEAR)
            stored_count = 0;
        else if (kind == OP_QUERY)
            pending_matches.insert(pending_matches.size(),
                                   nearest_stored(data[15:0], data[31:16], data[47:32]));
        // the unused kind leaves everything as it is
    endtask

    task automatic check_result(input match_t got);
        match_t want;
        if (pending_matches.size() == 0)
        begin
            report_mismatch("result transfer with no query pending", got, 0);
            return;
        end
        want = pending_matches.pop_front();
        if (got.label != want.label)
            report_mismatch("match_label", got.label, want.label);
        if (got.index != want.index)
            report_mismatch("match_index", got.index, want.index);
        if (got.distance != want.distance)
            report_mismatch("match_distance", got.distance, want.distance);
        if (got.empty != want.empty)
            report_mismatch("table_empty", got.empty, want.empty);
    endtask

    // Input side first, so a query is always queued before its result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_count   = 0;
            mismatch_count = 0;
            pending_matches.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                take_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_result('{label: m_tdata[2:0], index: m_tdata[10:3],
                               distance: m_tdata[44:11], empty: m_tuser});
        end
        matches_pending = pending_matches.size();
    end

endmodule

/* verif/tb_nearest_neighbor_classifier_core.sv */
// Top of the nearest neighbor classifier testbench: clock, reset, stimulus,
// output back-pressure, watchdog and verdict.
// Depends on nnc_pkg, the classifier core and nnc_match_checker.
`timescale 1ns / 100ps

module tb_nearest_neighbor_classifier_core;
    import nnc_pkg::*;

    localparam int              TABLE_DEPTH = 256;
    localparam int              ITEM_TARGET = 1450;
    localparam int              IDLE_LIMIT  = 20000;
    localparam int              LONG_HOLD   = 400;
    localparam int              DRAIN_WAIT  = 300;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = OP_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    int mismatch_count;
    int matches_pending;
    int items_sent    = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int idle_cycles   = 0;

    // Samples loaded since the last clear, used to aim queries near them
    logic signed [AXIS_W-1:0] loaded_fwd  [TABLE_DEPTH];
    logic signed [AXIS_W-1:0] loaded_vert [TABLE_DEPTH];
    logic signed [AXIS_W-1:0] loaded_gyro [TABLE_DEPTH];
    int                       loaded_n = 0;

    nearest_neighbor_classifier_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    nnc_match_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .matches_pending (matches_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Axis values weighted toward the extremes and small magnitudes
    function automatic logic signed [AXIS_W-1:0] rand_axis();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'($urandom_range(0, 16) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic signed [AXIS_W-1:0] near_axis(input logic signed [AXIS_W-1:0] base);
        return base + 16'($urandom_range(0, 6) - 3);
    endfunction

    // One input transfer; the sender runs in bursts with random gaps between
    task automatic send_item(input logic [KIND_W-1:0]      kind,
                             input logic signed [AXIS_W-1:0] f,
                             input logic signed [AXIS_W-1:0] v,
                             input logic signed [AXIS_W-1:0] g,
                             input logic [LABEL_W-1:0]     label);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, label, g, v, f};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        if (kind == OP_LOAD && loaded_n < TABLE_DEPTH)
        begin
            loaded_fwd[loaded_n]  = f;
            loaded_vert[loaded_n] = v;
            loaded_gyro[loaded_n] = g;
            loaded_n++;
        end
        else if (kind == OP_CLEAR)
            loaded_n = 0;
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    // Receiver: segments of differing stall patterns, plus requested long hold-offs
    initial
    begin
        int  seg_left;
        int  mode;
        logic toggle;
        seg_left = 0;
        mode     = 0;
        toggle   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                holds_done++;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                toggle = ~toggle;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 5) == 0);
                    default: m_tready <= toggle;
                endcase
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int nload;
        int nq;
        int pick;
        int round;
        logic signed [AXIS_W-1:0] qf;
        logic signed [AXIS_W-1:0] qv;
        logic signed [AXIS_W-1:0] qg;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, unused kind, extremes, ties, clear
        send_item(OP_QUERY, 16'sh1234, -16'sd5, 16'sh7FFF, 3'd4);
        send_item(KIND_UNUSED, 16'sh7FFF, 16'sh8000, 16'sh5555, 3'd7);
        send_item(OP_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 3'd7);
        send_item(OP_QUERY, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 3'd0);
        send_item(OP_LOAD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 3'd6);
        send_item(OP_QUERY, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 3'd0);
        send_item(OP_LOAD, 16'sd10, 16'sd0, 16'sd0, 3'd1);
        send_item(OP_LOAD, -16'sd10, 16'sd0, 16'sd0, 3'd2);
        // equal distance to two samples: the earlier one wins
        send_item(OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 3'd7);
        // identical sample stored twice
        send_item(OP_LOAD, 16'sd10, 16'sd0, 16'sd0, 3'd5);
        send_item(OP_QUERY, 16'sd10, 16'sd0, 16'sd0, 3'd3);
        send_item(OP_CLEAR, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 3'd7);
        send_item(OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 3'd0);
        send_item(OP_LOAD, 16'sd0, 16'sd0, 16'sd0, 3'd0);
        send_item(OP_QUERY, -16'sd1, 16'sd2, -16'sd3, 3'd0);
        send_item(KIND_UNUSED, 16'sd0, 16'sd0, 16'sd0, 3'd0);
        send_item(OP_QUERY, 16'sh8000, 16'sh7FFF, 16'sh8000, 3'd2);
        send_item(OP_CLEAR, 16'sd0, 16'sd0, 16'sd0, 3'd0);

        // Back-pressure: receiver holds off while queries keep coming
        repeat (8)
            send_item(OP_LOAD, rand_axis(), rand_axis(), rand_axis(), 3'($urandom_range(0, 7)));
        hold_requests++;
        repeat (12)
            send_item(OP_QUERY, rand_axis(), rand_axis(), rand_axis(), 3'($urandom_range(0, 7)));

        // Random rounds: optional clear, a run of loads, then queries
        round = 0;
        while (items_sent < ITEM_TARGET)
        begin
            round++;
            if ($urandom_range(0, 4) == 0)
                send_item(OP_CLEAR, rand_axis(), rand_axis(), rand_axis(),
                          3'($urandom_range(0, 7)));
            // now and then load close to or past the table depth
            if (round == 3 || $urandom_range(0, 49) == 0)
                nload = $urandom_range(240, 270);
            else
                nload = $urandom_range(0, 12);
            repeat (nload)
            begin
                if (loaded_n > 0 && $urandom_range(0, 7) == 0)
                begin
                    // duplicate an earlier sample to set up a tie
                    pick = $urandom_range(0, loaded_n - 1);
                    qf = loaded_fwd[pick];
                    qv = loaded_vert[pick];
                    qg = loaded_gyro[pick];
                end
                else
                begin
                    qf = rand_axis();
                    qv = rand_axis();
                    qg = rand_axis();
                end
                send_item(OP_LOAD, qf, qv, qg, 3'($urandom_range(0, 7)));
            end
            nq = $urandom_range(1, 6);
            repeat (nq)
            begin
                if (loaded_n > 0 && $urandom_range(0, 2) != 0)
                begin
                    pick = $urandom_range(0, loaded_n - 1);
                    qf = near_axis(loaded_fwd[pick]);
                    qv = near_axis(loaded_vert[pick]);
                    qg = near_axis(loaded_gyro[pick]);
                end
                else
                begin
                    qf = rand_axis();
                    qv = rand_axis();
                    qg = rand_axis();
                end
                send_item(OP_QUERY, qf, qv, qg, 3'($urandom_range(0, 7)));
            end
            if ($urandom_range(0, 15) == 0)
                send_item(KIND_UNUSED, rand_axis(), rand_axis(), rand_axis(),
                          3'($urandom_range(0, 7)));
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (matches_pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && matches_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
